@@ rtl/led_matrix_16x16_row_scroller_top_macros.svh @@
// Assertion macros for the row scroller.
// Taken in by the top level; depends on nothing else.
`ifndef LED_MATRIX_16X16_ROW_SCROLLER_TOP_MACROS_SVH
`define LED_MATRIX_16X16_ROW_SCROLLER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LMRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LMRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/lmrs_pkg.sv @@
// Shared types, constants and helpers for the LED matrix row scroller.
// No dependencies; imported by lmrs_modstep and the top level.
package lmrs_pkg;

	localparam int MAX_ROWS_DEF     = 256;
	localparam int DISPLAY_ROWS_DEF = 16;
	localparam int CFG_DW           = 9;
	localparam int HOLD_W           = 8;
	localparam int BYTE_W           = 8;
	localparam int INDEX_W          = 8;

	localparam logic [CFG_DW-1:0] CONTENT_ROWS_RST = 9'd16;
	localparam logic [HOLD_W-1:0] SCROLL_HOLD_RST  = 8'd0;

	typedef enum logic {
		CMD_WRITE   = 1'b0,
		CMD_REFRESH = 1'b1
	} cmd_t;

	typedef enum logic {
		REG_CONTENT_ROWS = 1'b0,
		REG_SCROLL_HOLD  = 1'b1
	} reg_index_t;

	// Mode of the shared compare/subtract unit
	typedef enum logic {
		STEP_SUB  = 1'b0,	// a >= m ? a - m : a (one restoring division step)
		STEP_WRAP = 1'b1	// a >= m ? 0 : a (increment wrap)
	} step_mode_t;

	function automatic logic [BYTE_W-1:0] reverse8(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] r;
		r = '0;
		for (int k = 0; k < BYTE_W; k++) begin
			r[BYTE_W-1-k] = b[k];
		end
		return r;
	endfunction

endpackage

@@ rtl/lmrs_modstep.sv @@
// Shared compare/subtract unit of the row scroller sequencer.
// Depends on lmrs_pkg for the step mode type.
module lmrs_modstep
	import lmrs_pkg::*;
#(
	parameter int UW = 10
) (
	input  logic [UW-1:0] a,
	input  logic [UW-1:0] m,
	input  step_mode_t    mode,
	output logic [UW-1:0] y
);

	logic ge;

	assign ge = (a >= m);

	always_comb begin
		case (mode)
			STEP_SUB:  y = ge ? (a - m) : a;
			STEP_WRAP: y = ge ? '0 : a;
			default:   y = a;
		endcase
	end

endmodule

@@ rtl/led_matrix_16x16_row_scroller_top.sv @@
// Top level of the 16x16 scrolling LED matrix row driver.
// Depends on lmrs_pkg, lmrs_modstep and the assertion macro header.
//
// A write item (cmd 0) stores {left_byte, right_byte} at row_index; indexes at
// or beyond MAX_ROWS are dropped. A refresh item (cmd 1) gives DISPLAY_ROWS output items,
// one per display row i, carrying the active-low select ~(1<<i), the bit-reversed bytes of
// stored row (i + offset) mod rows, and last on the final one. rows is content_rows with
// zero read as one and values above MAX_ROWS clipped. In a refresh the start row is found
// by a restoring division of the offset by rows, one bit a cycle through the single
// compare/subtract unit; then the S_LOAD state primes the registered read of the frame
// store and one item leaves per cycle while out_ready is high, the same unit wrapping the
// row pointer. in_ready is low for the whole refresh. After the frame the hold counter
// advances and, once it exceeds scroll_hold, clears and steps the offset (a hold of 255
// freezes scroll). Configuration writes are meant for idle periods only. The frame store
// has no reset.
`include "led_matrix_16x16_row_scroller_top_macros.svh"

module led_matrix_16x16_row_scroller_top
	import lmrs_pkg::*;
#(
	parameter int MAX_ROWS     = MAX_ROWS_DEF,
	parameter int DISPLAY_ROWS = DISPLAY_ROWS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    cfg_we,
	input  logic                    cfg_index,
	input  logic [CFG_DW-1:0]       cfg_data,
	// input items
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    cmd,
	input  logic [INDEX_W-1:0]      row_index,
	input  logic [BYTE_W-1:0]       left_byte,
	input  logic [BYTE_W-1:0]       right_byte,
	// output items
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [DISPLAY_ROWS-1:0] row_select,
	output logic [BYTE_W-1:0]       right_bits,
	output logic [BYTE_W-1:0]       left_bits,
	output logic                    last
);

	localparam int AW   = $clog2(MAX_ROWS);		// store address / offset width
	localparam int RW   = $clog2(MAX_ROWS + 1);	// row count width
	localparam int UW   = RW + 1;				// shared unit width
	localparam int CNTW = $clog2(AW + 1);
	localparam int WW   = $clog2(DISPLAY_ROWS);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_MOD  = 4'b0010,
		S_LOAD = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t              state_q;
	logic [CFG_DW-1:0]   content_rows_q;
	logic [HOLD_W-1:0]   scroll_hold_q;
	logic [AW-1:0]       off_q;
	logic [HOLD_W-1:0]   hold_q;
	logic [RW-1:0]       rem_q;
	logic [AW-1:0]       dvd_q;
	logic [CNTW-1:0]     cnt_q;
	logic [AW-1:0]       r_q;
	logic [WW-1:0]       word_q;
	logic [2*BYTE_W-1:0] rd_q;

	logic [2*BYTE_W-1:0] mem [MAX_ROWS];

	logic [RW-1:0]       rows;
	logic [UW-1:0]       unit_a;
	logic [UW-1:0]       unit_y;
	step_mode_t          unit_mode;
	logic                last_w;
	logic                in_acc;
	logic                out_acc;
	logic                wr_en;
	logic                rd_en;
	logic [AW-1:0]       rd_addr;
	logic [HOLD_W-1:0]   hold_next;

	// Effective row count: zero reads as one, clip to the store depth
	always_comb begin
		if (content_rows_q == '0) begin
			rows = RW'(1);
		end else if (32'(content_rows_q) > 32'(MAX_ROWS)) begin
			rows = RW'(MAX_ROWS);
		end else begin
			rows = RW'(content_rows_q);
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign in_acc    = in_valid && in_ready;
	assign out_acc   = out_valid && out_ready;
	assign last_w    = (word_q == WW'(DISPLAY_ROWS - 1));
	assign hold_next = hold_q + HOLD_W'(1);

	// Feed the shared unit: division steps, then row pointer wrap, offset wrap at the end
	always_comb begin
		unit_mode = STEP_WRAP;
		unit_a    = UW'(r_q) + UW'(1);
		if (state_q == S_MOD) begin
			unit_mode = STEP_SUB;
			unit_a    = {rem_q, dvd_q[AW-1]};
		end else if (last_w) begin
			unit_a    = UW'(off_q) + UW'(1);
		end
	end

	lmrs_modstep #(
		.UW(UW)
	) u_step (
		.a    (unit_a),
		.m    (UW'(rows)),
		.mode (unit_mode),
		.y    (unit_y)
	);

	// Frame store: one write port, one registered read port
	assign wr_en   = in_acc && (cmd == CMD_WRITE) && (32'(row_index) < 32'(MAX_ROWS));
	assign rd_en   = (state_q == S_LOAD) || (out_acc && !last_w);
	assign rd_addr = (state_q == S_LOAD) ? rem_q[AW-1:0] : unit_y[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[AW'(row_index)] <= {left_byte, right_byte};
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_rows_q <= CONTENT_ROWS_RST;
			scroll_hold_q  <= SCROLL_HOLD_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_CONTENT_ROWS: content_rows_q <= cfg_data;
				REG_SCROLL_HOLD:  scroll_hold_q  <= cfg_data[HOLD_W-1:0];
				default:          content_rows_q <= content_rows_q;
			endcase
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			off_q   <= '0;
			hold_q  <= '0;
			rem_q   <= '0;
			dvd_q   <= '0;
			cnt_q   <= '0;
			r_q     <= '0;
			word_q  <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					// start a refresh: remainder of offset by rows, MSB first
					if (in_acc && (cmd == CMD_REFRESH)) begin
						rem_q   <= '0;
						dvd_q   <= off_q;
						cnt_q   <= CNTW'(AW);
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					rem_q <= unit_y[RW-1:0];
					dvd_q <= dvd_q << 1;
					cnt_q <= cnt_q - CNTW'(1);
					if (cnt_q == CNTW'(1)) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					// read of the first row is issued this cycle
					r_q     <= rem_q[AW-1:0];
					word_q  <= '0;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_acc) begin
						if (last_w) begin
							// frame done: advance hold, step the offset on expiry
							if (hold_next > scroll_hold_q) begin
								hold_q <= '0;
								off_q  <= unit_y[AW-1:0];
							end else begin
								hold_q <= hold_next;
							end
							state_q <= S_IDLE;
						end else begin
							r_q    <= unit_y[AW-1:0];
							word_q <= word_q + WW'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Output item fields, all from registers
	assign row_select = ~(DISPLAY_ROWS'(1) << word_q);
	assign right_bits = reverse8(rd_q[BYTE_W-1:0]);
	assign left_bits  = reverse8(rd_q[2*BYTE_W-1:BYTE_W]);
	assign last       = last_w;

	// Checks
	`LMRS_ASSERT_NOW(a_no_overlap, clk, arst_n, out_valid, !in_ready, "input taken during a frame")
	`LMRS_ASSERT_NOW(a_row_in_range, clk, arst_n, out_valid, (32'(r_q) < 32'(rows)), "row pointer beyond row count")
	`LMRS_ASSERT_NEXT(a_frame_end, clk, arst_n, out_valid && out_ready && last, in_ready, "no return to idle after frame")
	`LMRS_ASSERT_NEXT(a_refresh_busy, clk, arst_n, in_valid && in_ready && (cmd == CMD_REFRESH), !in_ready && !out_valid, "refresh did not start division")

endmodule
